// File: sv/tw_odo_pkg.sv
// Shared types and constants of the three wheel odometry core.
package tw_odo_pkg;

    localparam int DATA_W      = 32;
    localparam int ANGLE_W     = 33;
    localparam int SUM_MAG_W   = 34;
    localparam int DS_MAG_W    = 33;
    localparam int DIST_W      = 49;
    localparam int TM_W        = 34;
    localparam int TERM_W      = 53;
    localparam int INC_W       = 54;
    localparam int CFG_INDEX_W = 1;
    localparam int ATAN_DEPTH  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADING  = 1'd1;

    localparam logic [DATA_W-1:0] DISTANCE_RESET = 32'd149922630;
    localparam logic [DATA_W-1:0] HEADING_RESET  = 32'd1988410;

    localparam logic signed [DATA_W-1:0] CORDIC_GAIN = 32'sd652032875;

    localparam logic [DATA_W-1:0] ATAN_TABLE [0:ATAN_DEPTH-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic                        valid;
        logic [1:0]                  quad;
        logic signed [DATA_W-1:0]    x;
        logic signed [DATA_W-1:0]    y;
        logic signed [ANGLE_W-1:0]   z;
    } t_cordic;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_FWD_LO,
        ST_FWD_HI,
        ST_SIDE_LO,
        ST_SIDE_HI,
        ST_SIDE_ADD,
        ST_TRIG_WAIT,
        ST_PROD,
        ST_SAT,
        ST_DONE
    } t_state;

endpackage

// File: sv/three_wheel_odometry_core.sv
// Top level of the three tracking wheel odometry core.
// The first item after reset is a baseline: it only stores the counts, and its result holds the pose unchanged.
// Any later item passes through the CORDIC cell row and through one shared 32x32 multiplier
// that does the other products in turn.
// The next item is taken the cycle after a result enters the output register.
// Reset clears position, heading and baseline and restores the default scale registers.
module three_wheel_odometry_core #(
    parameter int POSITION_WIDTH = 48,
    parameter int TRIG_STEPS     = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // right_count [31:0], left_count [63:32], strafe_count [95:64]
    input  logic [95:0]                           i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // x_pos, y_pos, heading, zero fill
    output logic [((2*POSITION_WIDTH+32+7)/8)*8-1:0] o_m_tdata,
    input  logic                                  i_cfg_we,
    input  logic [tw_odo_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tw_odo_pkg::DATA_W-1:0]         i_cfg_data
);

    localparam int PW     = POSITION_WIDTH;
    localparam int OUT_W  = ((2*PW+32+7)/8)*8;
    localparam int PAD_W  = OUT_W - (2*PW+32);
    localparam int ACC_W  = ((PW > tw_odo_pkg::INC_W) ? PW : tw_odo_pkg::INC_W) + 1;
    localparam int DW     = tw_odo_pkg::DATA_W;

    tw_odo_pkg::t_state r_state;
    tw_odo_pkg::t_state n_state;

    logic [DW-1:0]          r_dist;
    logic [DW-1:0]          r_head_rate;
    logic signed [DW-1:0]   r_prev_right;
    logic signed [DW-1:0]   r_prev_left;
    logic signed [DW-1:0]   r_prev_strafe;
    logic                   r_base;
    logic [DW-1:0]          r_heading;
    logic signed [PW-1:0]   r_pos_x;
    logic signed [PW-1:0]   r_pos_y;

    logic [tw_odo_pkg::SUM_MAG_W-1:0] r_sum_mag;
    logic                             r_sum_neg;
    logic [tw_odo_pkg::DS_MAG_W-1:0]  r_ds_mag;
    logic                             r_ds_neg;
    logic [DW-1:0]                    r_diff;

    logic [tw_odo_pkg::DIST_W-1:0] r_fwd_mag;
    logic [tw_odo_pkg::DIST_W-1:0] r_side_mag;
    logic [DW-1:0]                 r_cos_mag;
    logic                          r_cos_neg;
    logic [DW-1:0]                 r_sin_mag;
    logic                          r_sin_neg;
    logic [3:0]                    r_k;
    logic [tw_odo_pkg::TM_W-1:0]   r_tm;
    logic signed [tw_odo_pkg::INC_W-1:0] r_inc_x;
    logic signed [tw_odo_pkg::INC_W-1:0] r_inc_y;
    logic [2*DW-1:0]               r_prod;

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  w_s_accept;
    logic                  w_start;
    logic                  w_load;
    logic [DW-1:0]         w_mul_a;
    logic [DW-1:0]         w_mul_b;

    logic signed [DW-1:0]  w_right;
    logic signed [DW-1:0]  w_left;
    logic signed [DW-1:0]  w_strafe;
    logic signed [DW:0]    w_dr;
    logic signed [DW:0]    w_dl;
    logic signed [DW:0]    w_ds;
    logic signed [DW+1:0]  w_sum;

    logic                  w_trig_valid;
    logic signed [DW-1:0]  w_cos;
    logic signed [DW-1:0]  w_sin;

    logic [1:0]            w_j_issue;
    logic [1:0]            w_j_done;
    logic [tw_odo_pkg::DIST_W-1:0] w_a_mag;
    logic [DW-1:0]         w_b_mag;
    logic [tw_odo_pkg::TERM_W-1:0] w_term_mag;
    logic                  w_term_neg;
    logic signed [tw_odo_pkg::INC_W-1:0] w_term;

    logic signed [ACC_W-1:0] w_sum_x;
    logic signed [ACC_W-1:0] w_sum_y;
    logic [PW-1:0]         w_sat_x;
    logic [PW-1:0]         w_sat_y;

    assign w_right  = i_s_tdata[31:0];
    assign w_left   = i_s_tdata[63:32];
    assign w_strafe = i_s_tdata[95:64];

    assign w_dr  = (DW+1)'(r_prev_right) - (DW+1)'(w_right);
    assign w_dl  = (DW+1)'(r_prev_left) - (DW+1)'(w_left);
    assign w_ds  = (DW+1)'(w_strafe) - (DW+1)'(r_prev_strafe);
    assign w_sum = (DW+2)'(w_dr) + (DW+2)'(w_dl);

    assign w_s_accept = i_s_tvalid & o_s_tready;

    tw_odo_cordic_chain #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_heading (r_heading),
        .o_valid   (w_trig_valid),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    // Product terms in order: forward*cos, side*sin, forward*sin, side*cos.
    assign w_j_issue = r_k[2:1];
    assign w_j_done  = r_k[2:1] - 2'd1;
    assign w_a_mag   = w_j_issue[0] ? r_side_mag : r_fwd_mag;
    assign w_b_mag   = (w_j_issue[1] == w_j_issue[0]) ? r_cos_mag : r_sin_mag;

    assign w_term_mag = tw_odo_pkg::TERM_W'(r_tm) + {r_prod[50:0], 2'b00};
    assign w_term     = w_term_neg ? -$signed({1'b0, w_term_mag})
                                   : $signed({1'b0, w_term_mag});

    always_comb begin
        unique case (w_j_done)
            2'd0:    w_term_neg = r_sum_neg ^ r_cos_neg;
            2'd1:    w_term_neg = ~(r_ds_neg ^ r_sin_neg);
            2'd2:    w_term_neg = r_sum_neg ^ r_sin_neg;
            default: w_term_neg = r_ds_neg ^ r_cos_neg;
        endcase
    end

    assign w_sum_x = ACC_W'(r_pos_x) + ACC_W'(r_inc_x);
    assign w_sum_y = ACC_W'(r_pos_y) + ACC_W'(r_inc_y);

    always_comb begin
        if ((&w_sum_x[ACC_W-1:PW-1]) || !(|w_sum_x[ACC_W-1:PW-1])) begin
            w_sat_x = w_sum_x[PW-1:0];
        end else begin
            w_sat_x = {w_sum_x[ACC_W-1], {(PW-1){~w_sum_x[ACC_W-1]}}};
        end
        if ((&w_sum_y[ACC_W-1:PW-1]) || !(|w_sum_y[ACC_W-1:PW-1])) begin
            w_sat_y = w_sum_y[PW-1:0];
        end else begin
            w_sat_y = {w_sum_y[ACC_W-1], {(PW-1){~w_sum_y[ACC_W-1]}}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tw_odo_pkg::ST_IDLE: begin
                if (w_s_accept) begin
                    n_state = r_base ? tw_odo_pkg::ST_HEAD : tw_odo_pkg::ST_DONE;
                end
            end
            tw_odo_pkg::ST_HEAD:     n_state = tw_odo_pkg::ST_FWD_LO;
            tw_odo_pkg::ST_FWD_LO:   n_state = tw_odo_pkg::ST_FWD_HI;
            tw_odo_pkg::ST_FWD_HI:   n_state = tw_odo_pkg::ST_SIDE_LO;
            tw_odo_pkg::ST_SIDE_LO:  n_state = tw_odo_pkg::ST_SIDE_HI;
            tw_odo_pkg::ST_SIDE_HI:  n_state = tw_odo_pkg::ST_SIDE_ADD;
            tw_odo_pkg::ST_SIDE_ADD: n_state = tw_odo_pkg::ST_TRIG_WAIT;
            tw_odo_pkg::ST_TRIG_WAIT: begin
                if (w_trig_valid) begin
                    n_state = tw_odo_pkg::ST_PROD;
                end
            end
            tw_odo_pkg::ST_PROD: begin
                if (r_k[3]) begin
                    n_state = tw_odo_pkg::ST_SAT;
                end
            end
            tw_odo_pkg::ST_SAT:      n_state = tw_odo_pkg::ST_DONE;
            tw_odo_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = tw_odo_pkg::ST_IDLE;
                end
            end
            default:                 n_state = tw_odo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == tw_odo_pkg::ST_IDLE);
        w_start    = (r_state == tw_odo_pkg::ST_FWD_HI);
        w_load     = (r_state == tw_odo_pkg::ST_DONE) && (!r_out_valid || i_m_tready);
        unique case (r_state)
            tw_odo_pkg::ST_HEAD: begin
                w_mul_a = r_diff;
                w_mul_b = r_head_rate;
            end
            tw_odo_pkg::ST_FWD_LO: begin
                w_mul_a = r_sum_mag[DW-1:0];
                w_mul_b = r_dist;
            end
            tw_odo_pkg::ST_FWD_HI: begin
                w_mul_a = DW'(r_sum_mag[tw_odo_pkg::SUM_MAG_W-1:DW]);
                w_mul_b = r_dist;
            end
            tw_odo_pkg::ST_SIDE_LO: begin
                w_mul_a = r_ds_mag[DW-1:0];
                w_mul_b = r_dist;
            end
            tw_odo_pkg::ST_SIDE_HI: begin
                w_mul_a = DW'(r_ds_mag[tw_odo_pkg::DS_MAG_W-1:DW]);
                w_mul_b = r_dist;
            end
            tw_odo_pkg::ST_PROD: begin
                w_mul_a = r_k[0] ? DW'(w_a_mag[tw_odo_pkg::DIST_W-1:DW])
                                 : w_a_mag[DW-1:0];
                w_mul_b = w_b_mag;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tw_odo_pkg::ST_IDLE;
            r_dist      <= tw_odo_pkg::DISTANCE_RESET;
            r_head_rate <= tw_odo_pkg::HEADING_RESET;
            r_base      <= 1'b0;
            r_heading   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_prev_right  <= '0;
            r_prev_left   <= '0;
            r_prev_strafe <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tw_odo_pkg::CFG_DISTANCE: r_dist      <= i_cfg_data;
                    tw_odo_pkg::CFG_HEADING:  r_head_rate <= i_cfg_data;
                endcase
            end
            if (w_s_accept) begin
                r_prev_right  <= w_right;
                r_prev_left   <= w_left;
                r_prev_strafe <= w_strafe;
                r_base        <= 1'b1;
            end
            if (r_state == tw_odo_pkg::ST_FWD_LO) begin
                r_heading <= r_heading + r_prod[DW-1:0];
            end
            if (r_state == tw_odo_pkg::ST_SAT) begin
                r_pos_x <= w_sat_x;
                r_pos_y <= w_sat_y;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_s_accept) begin
            r_sum_neg <= w_sum[DW+1];
            r_sum_mag <= w_sum[DW+1] ? tw_odo_pkg::SUM_MAG_W'(-w_sum)
                                     : tw_odo_pkg::SUM_MAG_W'(w_sum);
            r_ds_neg  <= w_ds[DW];
            r_ds_mag  <= w_ds[DW] ? tw_odo_pkg::DS_MAG_W'(-w_ds)
                                  : tw_odo_pkg::DS_MAG_W'(w_ds);
            r_diff    <= w_dr[DW-1:0] - w_dl[DW-1:0];
        end
        unique case (r_state)
            tw_odo_pkg::ST_FWD_HI: begin
                r_fwd_mag <= tw_odo_pkg::DIST_W'(r_prod[2*DW-1:17]);
            end
            tw_odo_pkg::ST_SIDE_LO: begin
                r_fwd_mag <= r_fwd_mag + {r_prod[33:0], 15'd0};
            end
            tw_odo_pkg::ST_SIDE_HI: begin
                r_side_mag <= tw_odo_pkg::DIST_W'(r_prod[2*DW-1:16]);
            end
            tw_odo_pkg::ST_SIDE_ADD: begin
                r_side_mag <= r_side_mag + {r_prod[32:0], 16'd0};
            end
            tw_odo_pkg::ST_TRIG_WAIT: begin
                r_cos_neg <= w_cos[DW-1];
                r_cos_mag <= w_cos[DW-1] ? DW'(-w_cos) : DW'(w_cos);
                r_sin_neg <= w_sin[DW-1];
                r_sin_mag <= w_sin[DW-1] ? DW'(-w_sin) : DW'(w_sin);
                r_k       <= '0;
                r_inc_x   <= '0;
                r_inc_y   <= '0;
            end
            tw_odo_pkg::ST_PROD: begin
                r_k <= r_k + 4'd1;
                if (r_k[0]) begin
                    r_tm <= r_prod[2*DW-1:30];
                end else if (r_k != 4'd0) begin
                    if (w_j_done[1]) begin
                        r_inc_y <= r_inc_y + w_term;
                    end else begin
                        r_inc_x <= r_inc_x + w_term;
                    end
                end
            end
            tw_odo_pkg::ST_DONE: begin
                if (w_load) begin
                    r_out_data <= {{PAD_W{1'b0}}, r_heading, r_pos_y, r_pos_x};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: sv/tw_odo_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift, registered toward its neighbor.
module tw_odo_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tw_odo_pkg::t_cordic i_stage,
    output tw_odo_pkg::t_cordic o_stage
);

    logic signed [tw_odo_pkg::DATA_W-1:0]  w_xs;
    logic signed [tw_odo_pkg::DATA_W-1:0]  w_ys;
    logic signed [tw_odo_pkg::ANGLE_W-1:0] w_atan;
    tw_odo_pkg::t_cordic                   n_stage;
    tw_odo_pkg::t_cordic                   r_stage;

    assign w_xs   = i_stage.x >>> STEP;
    assign w_ys   = i_stage.y >>> STEP;
    assign w_atan = $signed({1'b0, tw_odo_pkg::ATAN_TABLE[STEP]});

    always_comb begin
        n_stage       = i_stage;
        if (!i_stage.z[tw_odo_pkg::ANGLE_W-1]) begin
            n_stage.x = i_stage.x - w_ys;
            n_stage.y = i_stage.y + w_xs;
            n_stage.z = i_stage.z - w_atan;
        end else begin
            n_stage.x = i_stage.x + w_ys;
            n_stage.y = i_stage.y - w_xs;
            n_stage.z = i_stage.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: sv/tw_odo_cordic_chain.sv
// Row of CORDIC cells that turns a heading into its cosine and sine.
module tw_odo_cordic_chain #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [tw_odo_pkg::DATA_W-1:0]        i_heading,
    output logic                                 o_valid,
    output logic signed [tw_odo_pkg::DATA_W-1:0] o_cos,
    output logic signed [tw_odo_pkg::DATA_W-1:0] o_sin
);

    tw_odo_pkg::t_cordic w_link [0:TRIG_STEPS];
    tw_odo_pkg::t_cordic w_last;

    always_comb begin
        w_link[0].valid = i_start;
        w_link[0].quad  = i_heading[tw_odo_pkg::DATA_W-1 -: 2];
        w_link[0].x     = tw_odo_pkg::CORDIC_GAIN;
        w_link[0].y     = '0;
        w_link[0].z     = $signed({3'b000, i_heading[tw_odo_pkg::DATA_W-3:0]});
    end

    for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cell
        tw_odo_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_link[i]),
            .o_stage (w_link[i+1])
        );
    end

    assign w_last  = w_link[TRIG_STEPS];
    assign o_valid = w_last.valid;

    always_comb begin
        unique case (w_last.quad)
            2'd0: begin
                o_cos = w_last.x;
                o_sin = w_last.y;
            end
            2'd1: begin
                o_cos = -w_last.y;
                o_sin = w_last.x;
            end
            2'd2: begin
                o_cos = -w_last.x;
                o_sin = -w_last.y;
            end
            default: begin
                o_cos = w_last.y;
                o_sin = -w_last.x;
            end
        endcase
    end

endmodule

// File: test/three_wheel_odometry_core_tb.sv
// Self-checking testbench of the three wheel odometry core: directed table, then random walks, random and edge counts.
module three_wheel_odometry_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tw_odo_pkg::CFG_DISTANCE;
    import tw_odo_pkg::CFG_HEADING;
    import tw_odo_pkg::CFG_INDEX_W;

    localparam int POS_W        = 48;
    localparam int CORDIC_STEPS = 16;
    localparam int OUT_W        = ((2*POS_W+32+7)/8)*8;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 6;

    localparam logic [31:0] DIST_DEFAULT = 32'd149922630;
    localparam logic [31:0] TURN_DEFAULT = 32'd1988410;
    localparam longint      GAIN_Q30     = 652032875;

    localparam longint ARCTAN [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    localparam logic [31:0] EDGE_VALUES [0:3] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [31:0]      head;
    } pose_t;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_KNOWN,
        ROW_CFG
    } row_kind_t;

    // For configuration rows a is the register index and b the value.
    typedef struct packed {
        row_kind_t        kind;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [31:0]      head;
    } plan_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [95:0]            i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_W-1:0]       o_m_tdata;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [31:0]            i_cfg_data  = '0;

    three_wheel_odometry_core #(
        .POSITION_WIDTH(POS_W),
        .TRIG_STEPS    (CORDIC_STEPS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Odometry state as the block should hold it.
    longint      last_right  = 0;
    longint      last_left   = 0;
    longint      last_strafe = 0;
    longint      pos_x       = 0;
    longint      pos_y       = 0;
    logic [31:0] turn_angle  = '0;
    logic [31:0] dist_scale  = DIST_DEFAULT;
    logic [31:0] turn_scale  = TURN_DEFAULT;
    bit          primed      = 1'b0;

    pose_t       pending_poses [$];
    int          fail_count    = 0;
    int          samples_sent  = 0;
    int          poses_checked = 0;
    int          settings_used = 1;
    int          sat_count     = 0;
    int          cycle_count   = 0;
    int          burst_left    = 0;
    bit          calm          = 1'b0;
    logic [31:0] walk_r        = '0;
    logic [31:0] walk_l        = '0;
    logic [31:0] walk_s        = '0;
    rx_mode_t    rx_mode       = RX_OPEN;
    logic [7:0]  rx_phase      = '0;
    plan_row_t   plan [0:24];

    function automatic longint trunc_q30(input longint a, input longint c);
        longint unsigned am, cm, r;
        am = (a < 0) ? -a : a;
        cm = (c < 0) ? -c : c;
        r  = (((am >> 32) * cm) << 2) + (((am & 64'hFFFF_FFFF) * cm) >> 30);
        return ((a < 0) != (c < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void cordic_sincos(input logic [31:0] ang,
                                          output longint cs, output longint sn);
        longint x, y, z, xs, ys;
        x = GAIN_Q30;
        y = 0;
        z = longint'(ang[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN[i];
            end
        end
        case (ang[31:30])
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y;  sn = -x; end
        endcase
    endfunction

    function automatic longint clamp_add(input longint p, input longint inc);
        longint hi, lo;
        hi = (longint'(1) <<< (POS_W-1)) - 1;
        lo = -hi - 1;
        if (inc > 0 && p > hi - inc) begin
            sat_count++;
            return hi;
        end
        if (inc < 0 && p < lo - inc) begin
            sat_count++;
            return lo;
        end
        return p + inc;
    endfunction

    function automatic pose_t odo_update(input logic [31:0] r_in, l_in, s_in);
        longint r, l, s, dr, dl, ds, sum, fwd, side, cs, sn, prod;
        longint unsigned sm, dm, fm, smag;
        pose_t p;
        r = $signed(r_in);
        l = $signed(l_in);
        s = $signed(s_in);
        if (primed) begin
            dr   = -(r - last_right);
            dl   = -(l - last_left);
            ds   = s - last_strafe;
            sum  = dr + dl;
            sm   = (sum < 0) ? -sum : sum;
            dm   = (ds < 0) ? -ds : ds;
            fm   = (((sm >> 32) * dist_scale) << 15)
                 + (((sm & 64'hFFFF_FFFF) * dist_scale) >> 17);
            smag = (dm * dist_scale) >> 16;
            fwd  = (sum < 0) ? -longint'(fm) : longint'(fm);
            side = (ds < 0) ? -longint'(smag) : longint'(smag);
            prod = (dr - dl) * longint'(turn_scale);
            turn_angle = turn_angle + prod[31:0];
            cordic_sincos(turn_angle, cs, sn);
            pos_x = clamp_add(pos_x, trunc_q30(fwd, cs) - trunc_q30(side, sn));
            pos_y = clamp_add(pos_y, trunc_q30(fwd, sn) + trunc_q30(side, cs));
        end
        last_right  = r;
        last_left   = l;
        last_strafe = s;
        primed      = 1'b1;
        p.x    = pos_x[POS_W-1:0];
        p.y    = pos_y[POS_W-1:0];
        p.head = turn_angle;
        return p;
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_sample(input logic [31:0] r, l, s,
                               input bit use_typed, input pose_t typed);
        int    gap;
        pose_t want;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = calm ? 0 : $urandom_range(0, 45);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {s, l, r};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        want = odo_update(r, l, s);
        pending_poses.push_back(use_typed ? typed : want);
        walk_r = r;
        walk_l = l;
        walk_s = s;
        samples_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        i_cfg_we   <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_poses.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_DISTANCE)
            dist_scale = val;
        else if (idx == CFG_HEADING)
            turn_scale = val;
        settings_used++;
    endtask

    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase == 8'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= $urandom_range(0, 1);
            RX_SPARSE: i_m_tready <= (rx_phase[2:0] == 3'd5);
            default:   i_m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        pose_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x    = o_m_tdata[POS_W-1:0];
            got.y    = o_m_tdata[2*POS_W-1:POS_W];
            got.head = o_m_tdata[2*POS_W+31:2*POS_W];
            if (pending_poses.size() == 0) begin
                flag($sformatf("Unexpected pose x=%h y=%h heading=%h",
                               got.x, got.y, got.head));
            end else begin
                want = pending_poses.pop_front();
                poses_checked++;
                if (got.x != want.x || got.y != want.y || got.head != want.head)
                    flag($sformatf({"Pose %0d mismatch: x exp %h got %h, y exp %h got %h, ",
                                    "heading exp %h got %h"}, poses_checked,
                                   want.x, got.x, want.y, got.y, want.head, got.head));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d poses outstanding",
                     cycle_count, pending_poses.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          pick;
        int          fwd_step;
        int          turn_step;
        logic [31:0] r, l, s, d_val, h_val;

        plan = '{
            '{ROW_KNOWN,  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0},
            '{ROW_KNOWN,  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0},
            '{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0},
            '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC18, 32'hFFFF_FC18, 32'h0000_0000, '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC7C, 32'hFFFF_FBB4, 32'd50,        '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC7C, 32'hFFFF_FBB4, 32'hFFFF_EC78, '0, '0, '0},
            '{ROW_CFG,    32'(CFG_HEADING),  32'h4000_0000, '0,        '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC7B, 32'hFFFF_FBB4, 32'hFFFF_EC78, '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC7A, 32'hFFFF_FBB4, 32'hFFFF_EC78, '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC79, 32'hFFFF_FBB4, 32'hFFFF_EC78, '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC78, 32'hFFFF_FBB4, 32'hFFFF_EC78, '0, '0, '0},
            '{ROW_SAMPLE, 32'hFFFF_FC77, 32'hFFFF_FBB3, 32'hFFFF_F060, '0, '0, '0},
            '{ROW_CFG,    32'(CFG_DISTANCE), 32'hFFFF_FFFF, '0,        '0, '0, '0},
            '{ROW_CFG,    32'(CFG_HEADING),  32'h0000_0000, '0,        '0, '0, '0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, '0, '0, '0},
            '{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0},
            '{ROW_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0},
            '{ROW_CFG,    32'(CFG_HEADING),  32'hFFFF_FFFF, '0,        '0, '0, '0},
            '{ROW_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, '0, '0, '0},
            '{ROW_CFG,    32'(CFG_DISTANCE), 32'h0000_0000, '0,        '0, '0, '0},
            '{ROW_SAMPLE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '0, '0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG: begin
                    drain();
                    write_reg(plan[i].a[CFG_INDEX_W-1:0], plan[i].b);
                end
                ROW_KNOWN:
                    send_sample(plan[i].a, plan[i].b, plan[i].c, 1'b1,
                                '{plan[i].x, plan[i].y, plan[i].head});
                default:
                    send_sample(plan[i].a, plan[i].b, plan[i].c, 1'b0, '0);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin d_val = DIST_DEFAULT;  h_val = TURN_DEFAULT;  end
                1: begin d_val = 32'hFFFF_FFFF; h_val = 32'hFFFF_FFFF; end
                2: begin d_val = 32'h0;         h_val = $urandom;     end
                3: begin d_val = $urandom;      h_val = 32'h0;        end
                4: begin d_val = $urandom;      h_val = $urandom;     end
                default: begin
                    d_val = $urandom_range(0, 32'h00FF_FFFF);
                    h_val = $urandom_range(0, 32'h0400_0000);
                end
            endcase
            write_reg(CFG_DISTANCE, d_val);
            write_reg(CFG_HEADING, h_val);
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // Plausible motion: a forward step plus a small turn and slip.
                    fwd_step  = int'($urandom_range(0, 3000)) - 1000;
                    turn_step = int'($urandom_range(0, 400)) - 200;
                    r = walk_r - fwd_step - turn_step;
                    l = walk_l - fwd_step + turn_step;
                    s = walk_s + int'($urandom_range(0, 600)) - 300;
                end else if (pick < 88) begin
                    r = $urandom;
                    l = $urandom;
                    s = $urandom;
                end else begin
                    r = EDGE_VALUES[$urandom_range(0, 3)];
                    l = EDGE_VALUES[$urandom_range(0, 3)];
                    s = EDGE_VALUES[$urandom_range(0, 3)];
                end
                send_sample(r, l, s, 1'b0, '0);
            end
        end

        drain();
        repeat (CORDIC_STEPS + 25) @(posedge i_clk);
        if (pending_poses.size() != 0)
            flag($sformatf("%0d poses never arrived", pending_poses.size()));

        $display("Sent %0d encoder samples under %0d scale settings; %0d poses checked.",
                 samples_sent, settings_used, poses_checked);
        $display("Expected trace saturated a position %0d times; %0d failures.",
                 sat_count, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/tw_odo_pkg.sv
sv/tw_odo_cordic_cell.sv
sv/tw_odo_cordic_chain.sv
sv/three_wheel_odometry_core.sv
test/three_wheel_odometry_core_tb.sv
